>>> hw/rtl/tgd_pkg.sv
`default_nettype none
package tgd_pkg;

    // Swipe edge bits, shared by edge_start and edge_end.
    localparam logic [3:0] EDGE_TOP    = 4'd1;
    localparam logic [3:0] EDGE_BOTTOM = 4'd2;
    localparam logic [3:0] EDGE_LEFT   = 4'd4;
    localparam logic [3:0] EDGE_RIGHT  = 4'd8;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SCREEN_WIDTH      = 3'd0;
    localparam logic [2:0] CFG_SCREEN_HEIGHT     = 3'd1;
    localparam logic [2:0] CFG_EDGE_MARGIN       = 3'd2;
    localparam logic [2:0] CFG_EDGE_EXTRAPOLATE  = 3'd3;
    localparam logic [2:0] CFG_TAP_RADIUS        = 3'd4;
    localparam logic [2:0] CFG_HOLD_TIME_MS      = 3'd5;
    localparam logic [2:0] CFG_HOLD_CLICK_ENABLE = 3'd6;
    localparam logic [2:0] CFG_CLICK_ON_RELEASE  = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic [9:0]  edge_margin;
        logic        edge_extrapolate;
        logic [23:0] tap_radius_sq;
        logic [15:0] hold_time_ms;
        logic        hold_click_enable;
        logic        click_on_release;
    } t_cfg;

    typedef struct packed {
        logic        prev_down;
        logic        prev2_down;
        logic [12:0] prev_x;
        logic [12:0] prev_y;
        logic [12:0] start_x;
        logic [12:0] start_y;
        logic        tap_flag;
        logic        single_finger_flag;
        logic [31:0] hold_start_time;
        logic [3:0]  edge_flags;
    } t_state;

    typedef struct packed {
        logic        touch_down;
        logic [12:0] touch_x;
        logic [12:0] touch_y;
        logic        other_touch_down;
        logic [31:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic [3:0] edge_start;
        logic [3:0] edge_end;
        logic       right_click;
    } t_out_word;

endpackage
`default_nettype wire

>>> hw/rtl/tgd_in_if.sv
`default_nettype none
interface tgd_in_if;
    logic        valid;
    logic        ready;
    logic        touch_down;
    logic [12:0] touch_x;
    logic [12:0] touch_y;
    logic        other_touch_down;
    logic [31:0] now_ms;

    modport source (
        output valid, touch_down, touch_x, touch_y, other_touch_down, now_ms,
        input  ready
    );
    modport sink (
        input  valid, touch_down, touch_x, touch_y, other_touch_down, now_ms,
        output ready
    );
endinterface
`default_nettype wire

>>> hw/rtl/tgd_out_if.sv
`default_nettype none
interface tgd_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] edge_start;
    logic [3:0] edge_end;
    logic       right_click;

    modport source (
        output valid, edge_start, edge_end, right_click,
        input  ready
    );
    modport sink (
        input  valid, edge_start, edge_end, right_click,
        output ready
    );
endinterface
`default_nettype wire

>>> hw/rtl/touch_gesture_detector.sv
`default_nettype none
// Touch gesture detector. Each word on the input channel i_in is one touch
// frame: primary finger down, its x and y position, any other finger down,
// and a millisecond time stamp. For every input word exactly one word comes
// out on o_out: edge-swipe start bits, edge-swipe end bits at release, and
// the hold right-click flag.
// A frame is processed in the cycle it is accepted and its result sits in
// the output register in the next cycle. One word per cycle is sustained
// while the receiver takes results; the limit is the single frame step
// from the tracking registers back to themselves (two 14-bit squares and
// an add). The input stays ready while the output register is empty or is
// being taken in the same cycle. When the receiver stalls with a result
// waiting, the input drops ready and the pending result holds unchanged.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
// the block is idle (a user rule, not enforced). The squared tap radius is
// formed at write time. Synchronous active-low reset restores the register
// defaults, clears all tracking state and empties the output register.
module touch_gesture_detector (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    tgd_in_if.sink                           i_in,
    tgd_out_if.source                        o_out,
    input  wire                              i_cfg_we,
    input  wire [tgd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [tgd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    tgd_pkg::t_cfg      r_cfg;
    tgd_pkg::t_state    r_state;
    tgd_pkg::t_state    n_state;
    tgd_pkg::t_in_word  in_word;
    tgd_pkg::t_out_word n_out;
    tgd_pkg::t_out_word r_out;
    logic               r_out_valid;
    logic               in_accept;
    logic [23:0]        radius_sq;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    assign in_word.touch_down       = i_in.touch_down;
    assign in_word.touch_x          = i_in.touch_x;
    assign in_word.touch_y          = i_in.touch_y;
    assign in_word.other_touch_down = i_in.other_touch_down;
    assign in_word.now_ms           = i_in.now_ms;

    tgd_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_word   (in_word),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Squared tap radius, so the frame path compares against a register.
    assign radius_sq = {12'd0, i_cfg_data[11:0]} * {12'd0, i_cfg_data[11:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width      <= 13'd1920;
            r_cfg.screen_height     <= 13'd1080;
            r_cfg.edge_margin       <= 10'd1;
            r_cfg.edge_extrapolate  <= 1'b1;
            r_cfg.tap_radius_sq     <= 24'd900;
            r_cfg.hold_time_ms      <= 16'd1000;
            r_cfg.hold_click_enable <= 1'b1;
            r_cfg.click_on_release  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tgd_pkg::CFG_SCREEN_WIDTH:      r_cfg.screen_width      <= i_cfg_data[12:0];
                tgd_pkg::CFG_SCREEN_HEIGHT:     r_cfg.screen_height     <= i_cfg_data[12:0];
                tgd_pkg::CFG_EDGE_MARGIN:       r_cfg.edge_margin       <= i_cfg_data[9:0];
                tgd_pkg::CFG_EDGE_EXTRAPOLATE:  r_cfg.edge_extrapolate  <= i_cfg_data[0];
                tgd_pkg::CFG_TAP_RADIUS:        r_cfg.tap_radius_sq     <= radius_sq;
                tgd_pkg::CFG_HOLD_TIME_MS:      r_cfg.hold_time_ms      <= i_cfg_data;
                tgd_pkg::CFG_HOLD_CLICK_ENABLE: r_cfg.hold_click_enable <= i_cfg_data[0];
                tgd_pkg::CFG_CLICK_ON_RELEASE:  r_cfg.click_on_release  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.edge_start  = r_out.edge_start;
    assign o_out.edge_end    = r_out.edge_end;
    assign o_out.right_click = r_out.right_click;

endmodule
`default_nettype wire

>>> hw/rtl/tgd_step.sv
`default_nettype none
// Next-state and result logic for one frame.
module tgd_step (
    input  tgd_pkg::t_cfg      i_cfg,
    input  tgd_pkg::t_state    i_state,
    input  tgd_pkg::t_in_word  i_word,
    output tgd_pkg::t_state    o_state,
    output tgd_pkg::t_out_word o_result
);

    logic               touch_start;
    logic [12:0]        sx_eff;
    logic [12:0]        sy_eff;
    logic               sff_eff;
    logic               tap_eff;
    logic [31:0]        hst_eff;
    logic signed [13:0] dx;
    logic signed [13:0] dy;
    logic signed [27:0] dx_sq;
    logic signed [27:0] dy_sq;
    logic [26:0]        dist_sq;
    logic               tap_next;
    logic               eval_start;
    logic [13:0]        mdx_raw;
    logic [13:0]        mdy_raw;
    logic [13:0]        mdx;
    logic [13:0]        mdy;
    logic               vert;
    logic               horiz;
    logic [15:0]        ex;
    logic [15:0]        ey;
    logic [15:0]        margin;
    logic [15:0]        thr_x;
    logic [15:0]        thr_y;
    logic [3:0]         flags;
    logic [3:0]         flags_next;
    logic               sff_after_other;
    logic               click_phase;
    logic [31:0]        elapsed;
    logic               click;

    always_comb begin
        touch_start = i_word.touch_down && !i_state.prev_down;
        sx_eff  = touch_start ? i_word.touch_x : i_state.start_x;
        sy_eff  = touch_start ? i_word.touch_y : i_state.start_y;
        sff_eff = touch_start ? 1'b1 : i_state.single_finger_flag;
        tap_eff = touch_start ? 1'b1 : i_state.tap_flag;
        hst_eff = (touch_start && i_cfg.hold_click_enable) ? i_word.now_ms
                                                           : i_state.hold_start_time;

        // Tap test against the squared radius.
        dx = $signed({1'b0, i_word.touch_x}) - $signed({1'b0, sx_eff});
        dy = $signed({1'b0, i_word.touch_y}) - $signed({1'b0, sy_eff});
        dx_sq = dx * dx;
        dy_sq = dy * dy;
        dist_sq = {1'b0, dx_sq[25:0]} + {1'b0, dy_sq[25:0]};
        tap_next = tap_eff && !(i_word.touch_down && (dist_sq >= {3'b0, i_cfg.tap_radius_sq}));

        // Edge start: first frame, or second frame when extrapolating back.
        eval_start = i_word.touch_down && sff_eff &&
                     (i_cfg.edge_extrapolate ? (i_state.prev_down && !i_state.prev2_down)
                                             : !i_state.prev_down);
        mdx_raw = {1'b0, i_word.touch_x} - {1'b0, i_state.prev_x};
        mdy_raw = {1'b0, i_word.touch_y} - {1'b0, i_state.prev_y};
        mdx = mdx_raw[13] ? (14'd0 - mdx_raw) : mdx_raw;
        mdy = mdy_raw[13] ? (14'd0 - mdy_raw) : mdy_raw;
        if (i_cfg.edge_extrapolate) begin
            ex    = {2'b0, i_state.prev_x, 1'b0} - {3'b0, i_word.touch_x};
            ey    = {2'b0, i_state.prev_y, 1'b0} - {3'b0, i_word.touch_y};
            vert  = mdy >= mdx;
            horiz = mdy <= mdx;
        end else begin
            ex    = {3'b0, i_word.touch_x};
            ey    = {3'b0, i_word.touch_y};
            vert  = 1'b1;
            horiz = 1'b1;
        end
        margin = {6'b0, i_cfg.edge_margin};
        thr_x  = {3'b0, i_cfg.screen_width}  - 16'd1 - margin;
        thr_y  = {3'b0, i_cfg.screen_height} - 16'd1 - margin;
        flags = 4'd0;
        if (vert && ($signed(ey) <= $signed(margin))) begin
            flags = flags | tgd_pkg::EDGE_TOP;
        end
        if (vert && ($signed(ey) >= $signed(thr_y))) begin
            flags = flags | tgd_pkg::EDGE_BOTTOM;
        end
        if (horiz && ($signed(ex) <= $signed(margin))) begin
            flags = flags | tgd_pkg::EDGE_LEFT;
        end
        if (horiz && ($signed(ex) >= $signed(thr_x))) begin
            flags = flags | tgd_pkg::EDGE_RIGHT;
        end
        flags_next = eval_start ? flags : i_state.edge_flags;

        sff_after_other = sff_eff && !(i_word.touch_down && i_word.other_touch_down);

        // Hold click, either at release or while still held.
        click_phase = i_cfg.click_on_release ? !i_word.touch_down : i_word.touch_down;
        elapsed = i_word.now_ms - hst_eff;
        click = i_cfg.hold_click_enable && click_phase && i_state.prev_down &&
                sff_after_other && tap_next && (elapsed > {16'b0, i_cfg.hold_time_ms});

        o_state.prev_down          = i_word.touch_down;
        o_state.prev2_down         = i_state.prev_down;
        o_state.prev_x             = i_word.touch_x;
        o_state.prev_y             = i_word.touch_y;
        o_state.start_x            = sx_eff;
        o_state.start_y            = sy_eff;
        o_state.tap_flag           = tap_next;
        o_state.single_finger_flag = sff_after_other && !click;
        o_state.hold_start_time    = hst_eff;
        o_state.edge_flags         = flags_next;

        o_result.edge_start  = eval_start ? flags : 4'd0;
        o_result.edge_end    = (!i_word.touch_down && i_state.prev_down &&
                                i_state.single_finger_flag) ? i_state.edge_flags : 4'd0;
        o_result.right_click = click;
    end

endmodule
`default_nettype wire
